>>> hw/rtl/hsi_pkg.sv
`default_nettype none

package hsi_pkg;

    // Table geometry; slot indexing takes the low bits of the hash, so the size
    // is a power of two.
    localparam int SET_SIZE = 4096;
    localparam int SLOT_W   = $clog2(SET_SIZE);
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 13;

    localparam logic [KEY_W-1:0]   KEY_EMPTY     = '0;
    localparam logic [KEY_W-1:0]   KEY_ZERO_SUB  = '1;
    localparam logic [KEY_W-1:0]   HASH_MULT     = 32'd2654435761;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
    localparam logic [SLOT_W-1:0]  SLOT_LAST     = SLOT_W'(SET_SIZE - 1);

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic clear_wr;   // write zero at the sweep address
        logic load_key;   // take the incoming request
        logic rd_en;      // read the slot under the probe pointer
        logic check;      // resolve the slot just read
        logic load_out;   // move the result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hit;
        logic empty;
        logic probe_last;
    } dp_status_t;

    // Only the low SLOT_W bits of the 32-bit product are needed.
    function automatic slot_t home_slot(input key_t k);
        logic [2*SLOT_W-1:0] prod;
        begin
            prod = (2*SLOT_W)'(k[SLOT_W-1:0]) * (2*SLOT_W)'(HASH_MULT[SLOT_W-1:0]);
            return prod[SLOT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hsi_ram.sv
`default_nettype none

module hsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/hsi_datapath.sv
`default_nettype none

module hsi_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hsi_pkg::dp_cmd_t    cmd,
    output hsi_pkg::dp_status_t      status,
    input  wire hsi_pkg::key_t       key,
    output logic                     added,
    output logic                     already_present,
    output logic                     table_full,
    output hsi_pkg::count_t          distinct_total
);

    import hsi_pkg::*;

    slot_t  clr_addr_reg, clr_addr_next;
    count_t count_reg, count_next;
    key_t   key_reg;
    slot_t  pos_reg;
    slot_t  probe_reg;
    logic   res_added_reg, res_present_reg, res_full_reg;
    logic   out_added_reg, out_present_reg, out_full_reg;
    count_t out_total_reg;

    key_t   key_in;
    key_t   rd_data;
    logic   ins_wr;
    logic   mem_we;
    slot_t  mem_waddr;
    key_t   mem_wdata;

    assign key_in = (key == KEY_EMPTY) ? KEY_ZERO_SUB : key;

    assign status.clear_last = (clr_addr_reg == SLOT_LAST);
    assign status.hit        = (rd_data == key_reg);
    assign status.empty      = (rd_data == KEY_EMPTY);
    assign status.probe_last = (probe_reg == SLOT_LAST);

    // key_reg is never zero, so a hit and an empty slot exclude each other
    assign ins_wr    = cmd.check && status.empty && !status.hit;
    assign mem_we    = cmd.clear_wr || ins_wr;
    assign mem_waddr = cmd.clear_wr ? clr_addr_reg : pos_reg;
    assign mem_wdata = cmd.clear_wr ? KEY_EMPTY : key_reg;

    hsi_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SET_SIZE)
    ) u_slots (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (cmd.rd_en),
        .raddr (pos_reg),
        .rdata (rd_data)
    );

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        count_next    = count_reg;
        if (cmd.clear_wr)
        begin
            clr_addr_next = clr_addr_reg + SLOT_W'(1);
        end
        if (ins_wr && count_reg != COUNT_MAX)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg   <= key_in;
            pos_reg   <= home_slot(key_in);
            probe_reg <= '0;
        end
        else if (cmd.check)
        begin
            res_added_reg   <= ins_wr;
            res_present_reg <= status.hit;
            res_full_reg    <= !status.hit && !status.empty && status.probe_last;
            if (!status.hit && !status.empty)
            begin
                pos_reg   <= (pos_reg == SLOT_LAST) ? '0 : pos_reg + SLOT_W'(1);
                probe_reg <= probe_reg + SLOT_W'(1);
            end
        end
        if (cmd.load_out)
        begin
            out_added_reg   <= res_added_reg;
            out_present_reg <= res_present_reg;
            out_full_reg    <= res_full_reg;
            out_total_reg   <= count_reg;
        end
    end

    assign added           = out_added_reg;
    assign already_present = out_present_reg;
    assign table_full      = out_full_reg;
    assign distinct_total  = out_total_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hsi_ctrl.sv
`default_nettype none

module hsi_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output hsi_pkg::dp_cmd_t          cmd,
    input  wire hsi_pkg::dp_status_t  status
);

    import hsi_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       resolved;

    assign out_free = !out_valid_reg || !out_stall;
    assign resolved = status.hit || status.empty || status.probe_last;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    assign cmd.clear_wr = (state_reg == ST_CLEAR);
    assign cmd.load_key = (state_reg == ST_IDLE) && in_valid;
    assign cmd.rd_en    = (state_reg == ST_READ);
    assign cmd.check    = (state_reg == ST_CHECK);
    assign cmd.load_out = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = resolved ? ST_DONE : ST_READ;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a taken request holds the input side off while it probes
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not held off after a request was taken");

    // a new result only appears from the result state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the result state");

    // a stored key is never zero, so a slot cannot both match and be empty
    a_hit_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> !(status.hit && status.empty))
        else $error("slot read as both matching and empty");

    // the sweep finishes before any request is taken
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !cmd.load_key && !cmd.rd_en)
        else $error("table accessed during the clearing sweep");

endmodule

`default_nettype wire

>>> hw/rtl/hash_set_insert_linear_probe.sv
`default_nettype none

// Distinct-key counter on a 4096-slot open-addressing hash set with linear
// probing. After reset the block sweeps the slot memory to empty, one slot a
// cycle, holding in_stall high until the sweep ends. A request then probes
// slots from its home slot on (one when the home slot decides, up to 4096
// when the table is full): every probe is a read and a compare on the slot
// RAM with its registered read and own write port. A key of zero is stored
// as all ones. A finished result sits in the output register while the next
// request is taken; a further result waits until that register is free.
module hash_set_insert_linear_probe (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire hsi_pkg::key_t   key,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic                 added,
    output logic                 already_present,
    output logic                 table_full,
    output hsi_pkg::count_t      distinct_total
);

    import hsi_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    hsi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    hsi_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .key             (key),
        .added           (added),
        .already_present (already_present),
        .table_full      (table_full),
        .distinct_total  (distinct_total)
    );

endmodule

`default_nettype wire
